// ===== design/brbf_pkg.sv =====
// shared constants, codes and types of the circular byte fifo
package brbf_pkg;

    localparam int BUF_DEPTH = 1024;
    localparam int MAX_BLOCK = 8;

    localparam int IDX_W  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int LEN_W  = $clog2(BUF_DEPTH + 1);
    localparam int CNT_W  = 4;
    localparam int BYTE_W = 8;
    localparam int K_W    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLAIM = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WRITE,
        S_RD_ADDR,
        S_RD_DATA,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic              accepted;
        logic [CNT_W-1:0]  moved_count;
        logic [BYTE_W-1:0] data_byte;
        logic [IDX_W-1:0]  claim_offset;
        logic [LEN_W-1:0]  fill_level;
        logic              last;
    } t_result;

endpackage

// ===== design/byte_ring_buffer_block_fifo.sv =====
// circular byte fifo with block write, read, claim and clear operations
//
// One item is taken at a time; o_in_stall stays high until its results are handed to the output
// register. Writes, claims, clears and refusals pass decide and result states, writes also a
// write state per byte; a read passes an address and a data state per byte, as the single-port
// byte store reads into a register. Writing the length register empties the fifo; lengths
// below 2 act as 2 and above the store depth as the depth. One slot always stays free, so at
// most length - 1 bytes are held.
module byte_ring_buffer_block_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [brbf_pkg::LEN_W-1:0]       i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_op,
    input  logic [brbf_pkg::CNT_W-1:0]       i_count,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_0,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_1,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_2,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_3,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_4,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_5,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_6,
    input  logic [brbf_pkg::BYTE_W-1:0]      i_byte_7,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_accepted,
    output logic [brbf_pkg::CNT_W-1:0]       o_moved_count,
    output logic [brbf_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [brbf_pkg::IDX_W-1:0]       o_claim_offset,
    output logic [brbf_pkg::LEN_W-1:0]       o_fill_level,
    output logic                             o_last
);
    import brbf_pkg::*;

    t_state             r_state, n_state;
    t_op                r_op;
    logic [CNT_W-1:0]   r_cnt;
    logic [BYTE_W-1:0]  r_bytes [8];
    logic [K_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]   r_wr, n_wr;
    logic [IDX_W-1:0]   r_rd, n_rd;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [LEN_W-1:0]   r_span, n_span;
    t_result            r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic [BYTE_W-1:0]  r_mem [BUF_DEPTH];
    logic [BYTE_W-1:0]  r_rd_data;
    logic               mem_we;
    logic               mem_re;

    logic               accept;
    logic               out_free;
    logic [LEN_W:0]     fill_plus_cnt;
    logic [LEN_W:0]     rd_plus_cnt;
    logic [LEN_W-1:0]   wr_inc;
    logic [LEN_W-1:0]   rd_inc;
    logic [CNT_W-1:0]   k_ext;
    logic               k_last;
    t_result            refuse;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign fill_plus_cnt = {1'b0, r_fill} + (LEN_W+1)'(r_cnt);
    assign rd_plus_cnt   = (LEN_W+1)'(r_rd) + (LEN_W+1)'(r_cnt);
    assign wr_inc        = LEN_W'(r_wr) + LEN_W'(1);
    assign rd_inc        = LEN_W'(r_rd) + LEN_W'(1);
    assign k_ext         = CNT_W'(r_k);
    assign k_last        = (k_ext == r_cnt - CNT_W'(1));

    always_comb begin
        refuse              = '0;
        refuse.fill_level   = r_fill;
        refuse.last         = 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_fill      = r_fill;
        n_span      = r_span;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_k     = '0;
                n_res   = refuse;
                n_state = S_RESULT;
                if (r_op == OP_CLEAR) begin
                    n_wr           = '0;
                    n_rd           = '0;
                    n_fill         = '0;
                    n_res.accepted = 1'b1;
                    n_res.fill_level = '0;
                end else if (r_cnt > CNT_W'(MAX_BLOCK)) begin
                    n_res = refuse;
                end else begin
                    unique case (r_op)
                        OP_WRITE: begin
                            if (fill_plus_cnt < (LEN_W+1)'(r_span)) begin
                                n_res.accepted = 1'b1;
                                if (r_cnt != '0) begin
                                    n_state = S_WRITE;
                                end
                            end
                        end
                        OP_READ: begin
                            if (r_fill >= LEN_W'(r_cnt)) begin
                                n_fill           = r_fill - LEN_W'(r_cnt);
                                n_res.accepted   = 1'b1;
                                n_res.fill_level = r_fill - LEN_W'(r_cnt);
                                if (r_cnt != '0) begin
                                    n_state = S_RD_ADDR;
                                end
                            end
                        end
                        OP_CLAIM: begin
                            if (r_fill >= LEN_W'(r_cnt) &&
                                rd_plus_cnt <= (LEN_W+1)'(r_span)) begin
                                n_rd = (rd_plus_cnt >= (LEN_W+1)'(r_span)) ?
                                       '0 : IDX_W'(rd_plus_cnt);
                                n_fill             = r_fill - LEN_W'(r_cnt);
                                n_res.accepted     = 1'b1;
                                n_res.moved_count  = r_cnt;
                                n_res.claim_offset = r_rd;
                                n_res.fill_level   = r_fill - LEN_W'(r_cnt);
                            end
                        end
                        default: begin
                            n_res = refuse;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                mem_we = 1'b1;
                n_wr   = (wr_inc >= r_span) ? '0 : IDX_W'(wr_inc);
                n_k    = r_k + K_W'(1);
                if (k_last) begin
                    n_fill            = fill_plus_cnt[LEN_W-1:0];
                    n_res.moved_count = r_cnt;
                    n_res.fill_level  = fill_plus_cnt[LEN_W-1:0];
                    n_state           = S_RESULT;
                end
            end
            S_RD_ADDR: begin
                mem_re  = 1'b1;
                n_rd    = (rd_inc >= r_span) ? '0 : IDX_W'(rd_inc);
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = r_res;
                    n_out.moved_count = r_cnt;
                    n_out.data_byte   = r_rd_data;
                    n_out.last        = k_last;
                    n_k               = r_k + K_W'(1);
                    n_state           = k_last ? S_IDLE : S_RD_ADDR;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a length write empties the fifo
        if (i_cfg_wr_en) begin
            n_wr   = '0;
            n_rd   = '0;
            n_fill = '0;
            if (i_cfg_wr_data < LEN_W'(2)) begin
                n_span = LEN_W'(2);
            end else if (i_cfg_wr_data > LEN_W'(BUF_DEPTH)) begin
                n_span = LEN_W'(BUF_DEPTH);
            end else begin
                n_span = i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_wr        <= '0;
            r_rd        <= '0;
            r_fill      <= '0;
            r_span      <= LEN_W'(BUF_DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_fill      <= n_fill;
            r_span      <= n_span;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
        if (accept) begin
            r_op       <= t_op'(i_op);
            r_cnt      <= i_count;
            r_bytes[0] <= i_byte_0;
            r_bytes[1] <= i_byte_1;
            r_bytes[2] <= i_byte_2;
            r_bytes[3] <= i_byte_3;
            r_bytes[4] <= i_byte_4;
            r_bytes[5] <= i_byte_5;
            r_bytes[6] <= i_byte_6;
            r_bytes[7] <= i_byte_7;
        end
    end

    // byte store, one access per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr] <= r_bytes[r_k];
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out.accepted;
    assign o_moved_count  = r_out.moved_count;
    assign o_data_byte    = r_out.data_byte;
    assign o_claim_offset = r_out.claim_offset;
    assign o_fill_level   = r_out.fill_level;
    assign o_last         = r_out.last;

    // read index plus fill, wrapped, lands on the write index
    logic [LEN_W:0] chk_sum;
    logic [LEN_W:0] chk_wrap;
    assign chk_sum  = (LEN_W+1)'(r_rd) + (LEN_W+1)'(r_fill);
    assign chk_wrap = (chk_sum >= (LEN_W+1)'(r_span)) ?
                      chk_sum - (LEN_W+1)'(r_span) : chk_sum;

`ifndef SYNTHESIS
    a_fill_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < r_span)
        else $error("fill level reached the length in use");

    a_index_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LEN_W'(r_wr) < r_span) && (LEN_W'(r_rd) < r_span))
        else $error("index outside the length in use");

    // indices move byte by byte during an item, so only check between items
    a_index_fill_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (chk_wrap == (LEN_W+1)'(r_wr)))
        else $error("indices and fill level disagree");

    a_refusal_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_moved_count == '0) && o_last)
        else $error("refused item with moved bytes or without last mark");
`endif

endmodule

// ===== tb/tb.sv =====
// testbench of the circular byte fifo: scoreboard class, driver tasks and result checks
module tb;
    import brbf_pkg::*;

    class byte_fifo_scoreboard;
        logic [BYTE_W-1:0] bytes_held [BUF_DEPTH];
        int unsigned       wr_idx;
        int unsigned       rd_idx;
        int unsigned       fill;
        logic [LEN_W-1:0]  length_reg;
        t_result           pending_results [$];
        int                n_errors;

        function new();
            wr_idx     = 0;
            rd_idx     = 0;
            fill       = 0;
            length_reg = LEN_W'(BUF_DEPTH);
            n_errors   = 0;
        endfunction

        // lengths out of range are clamped to the store
        function int unsigned span();
            int unsigned n;
            n = length_reg;
            if (n < 2) n = 2;
            if (n > BUF_DEPTH) n = BUF_DEPTH;
            return n;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void set_length(logic [LEN_W-1:0] len);
            length_reg = len;
            wr_idx     = 0;
            rd_idx     = 0;
            fill       = 0;
        endfunction

        function void push(logic acc, int unsigned moved, logic [BYTE_W-1:0] data,
                           int unsigned offset, logic is_last);
            t_result r;
            r.accepted     = acc;
            r.moved_count  = CNT_W'(moved);
            r.data_byte    = data;
            r.claim_offset = IDX_W'(offset);
            r.fill_level   = LEN_W'(fill);
            r.last         = is_last;
            pending_results.push_back(r);
        endfunction

        function void note_op(logic [1:0] op, logic [CNT_W-1:0] count, logic [63:0] bytes);
            int unsigned       cnt;
            int unsigned       n;
            int unsigned       start;
            logic [BYTE_W-1:0] got [MAX_BLOCK];
            cnt = count;
            n   = span();
            if (op == OP_CLEAR) begin
                wr_idx = 0;
                rd_idx = 0;
                fill   = 0;
                push(1'b1, 0, '0, 0, 1'b1);
                return;
            end
            if (cnt > MAX_BLOCK) begin
                push(1'b0, 0, '0, 0, 1'b1);
                return;
            end
            case (op)
                OP_WRITE: begin
                    if (fill + cnt < n) begin
                        for (int k = 0; k < cnt; k++) begin
                            bytes_held[wr_idx] = bytes[8*k +: 8];
                            wr_idx = (wr_idx + 1 >= n) ? 0 : wr_idx + 1;
                        end
                        fill += cnt;
                        push(1'b1, cnt, '0, 0, 1'b1);
                    end else begin
                        push(1'b0, 0, '0, 0, 1'b1);
                    end
                end
                OP_READ: begin
                    if (fill < cnt) begin
                        push(1'b0, 0, '0, 0, 1'b1);
                    end else if (cnt == 0) begin
                        push(1'b1, 0, '0, 0, 1'b1);
                    end else begin
                        for (int k = 0; k < cnt; k++) begin
                            got[k] = bytes_held[rd_idx];
                            rd_idx = (rd_idx + 1 >= n) ? 0 : rd_idx + 1;
                        end
                        fill -= cnt;
                        for (int k = 0; k < cnt; k++)
                            push(1'b1, cnt, got[k], 0, k + 1 == cnt);
                    end
                end
                default: begin
                    // a claim must not cross the wrap point
                    if (fill >= cnt && rd_idx + cnt <= n) begin
                        start  = rd_idx;
                        rd_idx = (rd_idx + cnt >= n) ? 0 : rd_idx + cnt;
                        fill  -= cnt;
                        push(1'b1, cnt, '0, start, 1'b1);
                    end else begin
                        push(1'b0, 0, '0, 0, 1'b1);
                    end
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            n_errors++;
        endtask

        task check_result(t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                report_mismatch("result item with nothing expected");
                return;
            end
            exp = pending_results.pop_front();
            if (got.accepted !== exp.accepted)
                report_mismatch($sformatf("accepted %b, expected %b",
                                          got.accepted, exp.accepted));
            if (got.moved_count !== exp.moved_count)
                report_mismatch($sformatf("moved_count %0d, expected %0d",
                                          got.moved_count, exp.moved_count));
            if (got.data_byte !== exp.data_byte)
                report_mismatch($sformatf("data_byte %h, expected %h",
                                          got.data_byte, exp.data_byte));
            if (got.claim_offset !== exp.claim_offset)
                report_mismatch($sformatf("claim_offset %0d, expected %0d",
                                          got.claim_offset, exp.claim_offset));
            if (got.fill_level !== exp.fill_level)
                report_mismatch($sformatf("fill_level %0d, expected %0d",
                                          got.fill_level, exp.fill_level));
            if (got.last !== exp.last)
                report_mismatch($sformatf("last %b, expected %b", got.last, exp.last));
        endtask
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_wr_en    = 1'b0;
    logic [LEN_W-1:0]   cfg_wr_data  = '0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic [1:0]         in_op        = OP_WRITE;
    logic [CNT_W-1:0]   in_count     = '0;
    logic [BYTE_W-1:0]  in_byte [8]  = '{default: '0};
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic               out_accepted;
    logic [CNT_W-1:0]   out_moved;
    logic [BYTE_W-1:0]  out_data;
    logic [IDX_W-1:0]   out_offset;
    logic [LEN_W-1:0]   out_fill;
    logic               out_last;

    byte_fifo_scoreboard sb;
    int                  burst_left = 0;
    int                  stall_left = 0;
    int                  stall_mode = 0;

    byte_ring_buffer_block_fifo u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (in_op),
        .i_count        (in_count),
        .i_byte_0       (in_byte[0]),
        .i_byte_1       (in_byte[1]),
        .i_byte_2       (in_byte[2]),
        .i_byte_3       (in_byte[3]),
        .i_byte_4       (in_byte[4]),
        .i_byte_5       (in_byte[5]),
        .i_byte_6       (in_byte[6]),
        .i_byte_7       (in_byte[7]),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_accepted     (out_accepted),
        .o_moved_count  (out_moved),
        .o_data_byte    (out_data),
        .o_claim_offset (out_offset),
        .o_fill_level   (out_fill),
        .o_last         (out_last)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side: check every result item, stall in phases of changing density
    always @(posedge clk) begin : result_side
        t_result got;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            got.accepted     = out_accepted;
            got.moved_count  = out_moved;
            got.data_byte    = out_data;
            got.claim_offset = out_offset;
            got.fill_level   = out_fill;
            got.last         = out_last;
            sb.check_result(got);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 60);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic send_item(input logic [1:0] op, input logic [CNT_W-1:0] cnt,
                             input logic [63:0] bytes);
        in_valid <= 1'b1;
        in_op    <= op;
        in_count <= cnt;
        for (int k = 0; k < 8; k++)
            in_byte[k] <= bytes[8*k +: 8];
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_op(op, cnt, bytes);
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // bursts of back-to-back items with random gaps between them
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_for($urandom_range(1, 7));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(0, 5);
        end
    endtask

    task automatic put(input logic [1:0] op, input logic [CNT_W-1:0] cnt,
                       input logic [63:0] bytes);
        send_item(op, cnt, bytes);
        pace();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_length(len);
    endtask

    // mostly operations that succeed, sized from the current fill
    task automatic random_item();
        int          r;
        int          room;
        logic [1:0]  op;
        logic [3:0]  cnt;
        logic [63:0] bytes;
        r     = $urandom_range(0, 99);
        room  = int'(sb.span()) - 1 - int'(sb.fill);
        bytes = {$urandom, $urandom};
        if (r < 8) begin
            op  = 2'($urandom_range(0, 2));
            cnt = 4'($urandom_range(MAX_BLOCK + 1, 15));
        end else if (r < 12) begin
            op  = OP_CLEAR;
            cnt = 4'($urandom_range(0, 15));
        end else if (r < 50) begin
            op  = OP_WRITE;
            cnt = 4'(($urandom_range(0, 4) == 0 || room < 0) ? $urandom_range(0, MAX_BLOCK)
                : $urandom_range(0, (room < MAX_BLOCK) ? room : MAX_BLOCK));
        end else begin
            op  = (r < 85) ? OP_READ : OP_CLAIM;
            cnt = 4'(($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_BLOCK)
                : $urandom_range(0, (sb.fill < MAX_BLOCK) ? sb.fill : MAX_BLOCK));
        end
        put(op, cnt, bytes);
    endtask

    initial begin
        logic [LEN_W-1:0] lengths [8];
        sb = new();
        lengths = '{11'd9, 11'd2, 11'd17, 11'd1025, 11'd1, 11'd40, 11'd2047, 11'd0};
        lengths[5] = LEN_W'($urandom_range(3, 64));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty fifo, byte extremes, refusals and clear at the reset length
        put(OP_READ,  4'd0,  64'h0);
        put(OP_READ,  4'd1,  64'h0);
        put(OP_CLAIM, 4'd0,  64'h0);
        put(OP_CLAIM, 4'd1,  64'h0);
        put(OP_WRITE, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        put(OP_WRITE, 4'd8,  64'h00FF_00FF_00FF_00FF);
        put(OP_WRITE, 4'd8,  64'hFF00_FF00_FF00_FF00);
        put(OP_READ,  4'd8,  64'h0);
        put(OP_CLAIM, 4'd4,  64'h0);
        put(OP_CLEAR, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        put(OP_WRITE, 4'd15, 64'h1122_3344_5566_7788);
        put(OP_READ,  4'd9,  64'h0);
        put(OP_CLAIM, 4'd15, 64'h0);

        // full at length - 1, index wrap and a claim across the wrap point
        set_length(11'd9);
        put(OP_WRITE, 4'd8, {$urandom, $urandom});
        put(OP_WRITE, 4'd1, {$urandom, $urandom});
        put(OP_READ,  4'd5, 64'h0);
        put(OP_WRITE, 4'd5, {$urandom, $urandom});
        put(OP_CLAIM, 4'd4, 64'h0);
        put(OP_READ,  4'd4, 64'h0);
        put(OP_WRITE, 4'd8, {$urandom, $urandom});
        put(OP_READ,  4'd3, 64'h0);
        put(OP_CLAIM, 4'd3, 64'h0);
        put(OP_CLAIM, 4'd2, 64'h0);
        put(OP_READ,  4'd3, 64'h0);

        // length below the minimum acts as two
        set_length(11'd0);
        put(OP_WRITE, 4'd1, {$urandom, $urandom});
        put(OP_WRITE, 4'd1, {$urandom, $urandom});
        put(OP_READ,  4'd1, 64'h0);

        for (int p = 0; p < 8; p++) begin
            set_length(lengths[p]);
            for (int k = 0; k < 28; k++) begin
                random_item();
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        drain();
        if (sb.n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end
endmodule
